// ===== rtl/source_text_tokenizer_defines.svh =====
// Assertion macros shared by the checker of the source text tokenizer.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define STS_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sts_checker: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define STS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sts_checker: next-cycle check failed");

`endif

// ===== rtl/sts_pkg.sv =====
package sts_pkg;

   // Scanner mode kept between bytes.
   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_NUMBER,
      SCAN_IDENT,
      SCAN_OPER
   } scan_mode_type;

   // Token kind codes as they appear on the result port.
   typedef enum logic [5:0] {
      KIND_NUMBER = 6'd0,
      KIND_IDENT,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_LBRACK,
      KIND_RBRACK,
      KIND_LBRACE,
      KIND_RBRACE,
      KIND_COMMA,
      KIND_DOT,
      KIND_COLON,
      KIND_SEMI,
      KIND_ASSIGN,
      KIND_PLUS,
      KIND_MINUS,
      KIND_STAR,
      KIND_SLASH,
      KIND_LESS,
      KIND_GREATER,
      KIND_BAR,
      KIND_CARET,
      KIND_TILDE,
      KIND_BANG,
      KIND_INC,
      KIND_DEC,
      KIND_EQ,
      KIND_NE,
      KIND_LE,
      KIND_GE,
      KIND_AND,
      KIND_OR,
      KIND_END,
      KIND_ERR
   } kind_type;

   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_DEL        = 8'h7F;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   // One result word, already clamped to the port widths.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] line_no;
      logic [15:0] end_col;
      logic [15:0] token_len;
      logic [7:0]  bad_char;
   } result_type;

   // All results caused by one input byte; count is 1 to 3.
   typedef struct packed {
      result_type [2:0] slot;
      logic [1:0]       count;
   } bundle_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam logic [QPTR_W-1:0] QPTR_ONE  = QPTR_W'(1);
   localparam logic [QCNT_W-1:0] QCNT_ONE  = QCNT_W'(1);
   localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

   function automatic logic is_digit(input logic [7:0] b);
      is_digit = (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      is_alpha = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
   endfunction

   // Bytes that may open a two-character operator.
   function automatic logic is_pair_start(input logic [7:0] b);
      unique case (b)
         "+", "-", "=", "!", "<", ">", "&", "|": is_pair_start = 1'b1;
         default:                                is_pair_start = 1'b0;
      endcase
   endfunction

   // Kind of a one-character operator; KIND_ERR when the byte is none.
   function automatic kind_type single_kind(input logic [7:0] b);
      unique case (b)
         "(":     single_kind = KIND_LPAREN;
         ")":     single_kind = KIND_RPAREN;
         "[":     single_kind = KIND_LBRACK;
         "]":     single_kind = KIND_RBRACK;
         "{":     single_kind = KIND_LBRACE;
         "}":     single_kind = KIND_RBRACE;
         ",":     single_kind = KIND_COMMA;
         ".":     single_kind = KIND_DOT;
         ":":     single_kind = KIND_COLON;
         ";":     single_kind = KIND_SEMI;
         "=":     single_kind = KIND_ASSIGN;
         "+":     single_kind = KIND_PLUS;
         "-":     single_kind = KIND_MINUS;
         "*":     single_kind = KIND_STAR;
         "/":     single_kind = KIND_SLASH;
         "<":     single_kind = KIND_LESS;
         ">":     single_kind = KIND_GREATER;
         "|":     single_kind = KIND_BAR;
         "^":     single_kind = KIND_CARET;
         "~":     single_kind = KIND_TILDE;
         "!":     single_kind = KIND_BANG;
         default: single_kind = KIND_ERR;
      endcase
   endfunction

   // Kind of a two-character operator; KIND_ERR when the pair is none.
   function automatic kind_type pair_kind(input logic [7:0] a, input logic [7:0] b);
      unique case ({a, b})
         "++":    pair_kind = KIND_INC;
         "--":    pair_kind = KIND_DEC;
         "==":    pair_kind = KIND_EQ;
         "!=":    pair_kind = KIND_NE;
         "<=":    pair_kind = KIND_LE;
         ">=":    pair_kind = KIND_GE;
         "&&":    pair_kind = KIND_AND;
         "||":    pair_kind = KIND_OR;
         default: pair_kind = KIND_ERR;
      endcase
   endfunction

endpackage

// ===== rtl/sts_front.sv =====
module sts_front #(
   parameter int POS_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_ch,
   input  logic                req_last_byte,
   input  logic                q_full,
   output logic                req_stall,
   output logic                push_valid,
   output sts_pkg::bundle_type push_data
);

   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
   localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] POS_TWO = POS_WIDTH'(2);

   function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
      sat_inc = (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   function automatic logic [15:0] clamp_pos(input logic [POS_WIDTH-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      clamp_pos = (w[31:16] != 16'd0) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic sts_pkg::result_type make_res(
      input sts_pkg::kind_type      kind,
      input logic [POS_WIDTH-1:0]   line,
      input logic [POS_WIDTH-1:0]   endc,
      input logic [POS_WIDTH-1:0]   len,
      input logic [7:0]             bad
   );
      sts_pkg::result_type r;
      r.kind      = kind;
      r.line_no   = clamp_pos(line);
      r.end_col   = clamp_pos(endc);
      r.token_len = clamp_pos(len);
      r.bad_char  = bad;
      make_res    = r;
   endfunction

   sts_pkg::scan_mode_type mode_ff, mode_in, mode_fresh;
   logic [7:0]             pend_ff, pend_in, pend_fresh;
   logic [POS_WIDTH-1:0]   start_ff, start_in, start_fresh;
   logic [POS_WIDTH-1:0]   line_ff, line_in, line_fresh;
   logic [POS_WIDTH-1:0]   col_ff, col_in, col_next;
   logic                   end_seen_ff, end_seen_in;

   logic                   active;
   logic                   is_dig, is_alp, is_word, is_nl, is_blank, is_pstart;
   logic                   consumed, fresh_emit;
   sts_pkg::kind_type      sk, sk_pend, pk;
   sts_pkg::result_type    cand [4];
   logic [3:0]             cand_v;
   logic [2:0]             n_res;

   assign req_stall = q_full;
   assign active    = req_valid && !q_full && !end_seen_ff;

   // Byte classification and the scanner state after this byte, before the flush.
   always_comb begin
      is_dig    = sts_pkg::is_digit(req_ch);
      is_alp    = sts_pkg::is_alpha(req_ch);
      is_word   = is_dig || is_alp || (req_ch == sts_pkg::CH_UNDERSCORE);
      is_nl     = (req_ch == sts_pkg::CH_NEWLINE);
      is_blank  = (req_ch <= sts_pkg::CH_SPACE) || (req_ch == sts_pkg::CH_DEL);
      is_pstart = sts_pkg::is_pair_start(req_ch);
      sk        = sts_pkg::single_kind(req_ch);
      sk_pend   = sts_pkg::single_kind(pend_ff);
      pk        = sts_pkg::pair_kind(pend_ff, req_ch);

      consumed = ((mode_ff == sts_pkg::SCAN_NUMBER) && is_dig) ||
                 ((mode_ff == sts_pkg::SCAN_IDENT) && is_word) ||
                 ((mode_ff == sts_pkg::SCAN_OPER) && (pk != sts_pkg::KIND_ERR));
      col_next = is_nl ? POS_ONE : sat_inc(col_ff);

      mode_fresh  = (consumed && (mode_ff != sts_pkg::SCAN_OPER)) ? mode_ff
                                                                  : sts_pkg::SCAN_IDLE;
      start_fresh = start_ff;
      pend_fresh  = pend_ff;
      line_fresh  = line_ff;
      fresh_emit  = 1'b0;
      if (!consumed) begin
         if (is_dig) begin
            mode_fresh  = sts_pkg::SCAN_NUMBER;
            start_fresh = col_ff;
         end else if (is_alp) begin
            mode_fresh  = sts_pkg::SCAN_IDENT;
            start_fresh = col_ff;
         end else if (is_nl) begin
            line_fresh = sat_inc(line_ff);
         end else if (is_blank) begin
            fresh_emit = 1'b0;
         end else if (is_pstart) begin
            mode_fresh  = sts_pkg::SCAN_OPER;
            pend_fresh  = req_ch;
            start_fresh = col_ff;
         end else begin
            fresh_emit = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      start_in    = start_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      end_seen_in = end_seen_ff;
      if (active) begin
         mode_in     = req_last_byte ? sts_pkg::SCAN_IDLE : mode_fresh;
         pend_in     = pend_fresh;
         start_in    = start_fresh;
         line_in     = line_fresh;
         col_in      = col_next;
         end_seen_in = req_last_byte;
      end
   end

   // Results: close of the open token, a fresh one-byte token or error,
   // the flush on the final byte and the end token, packed in that order.
   always_comb begin
      cand_v[0] = (mode_ff == sts_pkg::SCAN_OPER) ||
                  ((mode_ff != sts_pkg::SCAN_IDLE) && !consumed);
      unique case (mode_ff)
         sts_pkg::SCAN_NUMBER:
            cand[0] = make_res(sts_pkg::KIND_NUMBER, line_ff, col_ff, col_ff - start_ff, 8'h00);
         sts_pkg::SCAN_IDENT:
            cand[0] = make_res(sts_pkg::KIND_IDENT, line_ff, col_ff, col_ff - start_ff, 8'h00);
         sts_pkg::SCAN_OPER: begin
            if (pk != sts_pkg::KIND_ERR)
               cand[0] = make_res(pk, line_ff, sat_inc(col_ff), POS_TWO, 8'h00);
            else if (sk_pend != sts_pkg::KIND_ERR)
               cand[0] = make_res(sk_pend, line_ff, sat_inc(start_ff), POS_ONE, 8'h00);
            else
               cand[0] = make_res(sts_pkg::KIND_ERR, line_ff, start_ff, '0, pend_ff);
         end
         sts_pkg::SCAN_IDLE:
            cand[0] = '0;
      endcase

      cand_v[1] = fresh_emit;
      if (sk != sts_pkg::KIND_ERR)
         cand[1] = make_res(sk, line_ff, sat_inc(col_ff), POS_ONE, 8'h00);
      else
         cand[1] = make_res(sts_pkg::KIND_ERR, line_ff, col_ff, '0, req_ch);

      // A pending operator at the flush was opened by this very byte.
      cand_v[2] = req_last_byte && (mode_fresh != sts_pkg::SCAN_IDLE);
      unique case (mode_fresh)
         sts_pkg::SCAN_NUMBER:
            cand[2] = make_res(sts_pkg::KIND_NUMBER, line_fresh, col_next,
                               col_next - start_fresh, 8'h00);
         sts_pkg::SCAN_IDENT:
            cand[2] = make_res(sts_pkg::KIND_IDENT, line_fresh, col_next,
                               col_next - start_fresh, 8'h00);
         sts_pkg::SCAN_OPER: begin
            if (sk != sts_pkg::KIND_ERR)
               cand[2] = make_res(sk, line_fresh, sat_inc(col_ff), POS_ONE, 8'h00);
            else
               cand[2] = make_res(sts_pkg::KIND_ERR, line_fresh, col_ff, '0, req_ch);
         end
         sts_pkg::SCAN_IDLE:
            cand[2] = '0;
      endcase

      cand_v[3] = req_last_byte;
      cand[3]   = make_res(sts_pkg::KIND_END, line_fresh, col_next, '0, 8'h00);

      push_data = '0;
      n_res     = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i] && (n_res < 3'd3)) begin
            push_data.slot[n_res[1:0]] = cand[i];
            n_res = n_res + 3'd1;
         end
      end
      push_data.count = n_res[1:0];
      push_valid      = active && (n_res != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sts_pkg::SCAN_IDLE;
         pend_ff     <= 8'h00;
         start_ff    <= '0;
         line_ff     <= POS_ONE;
         col_ff      <= '0;
         end_seen_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
         start_ff    <= start_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         end_seen_ff <= end_seen_in;
      end
   end

endmodule

// ===== rtl/sts_queue.sv =====
module sts_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  sts_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                q_full,
   output logic                head_valid,
   output sts_pkg::bundle_type head_data
);

   sts_pkg::bundle_type               q_ff [sts_pkg::QUEUE_DEPTH];
   logic [sts_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [sts_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [sts_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;

   assign q_full     = (cnt_ff == sts_pkg::QCNT_FULL);
   assign head_valid = (cnt_ff != '0);
   assign head_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + sts_pkg::QPTR_ONE : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + sts_pkg::QPTR_ONE : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_valid && !pop)
         cnt_in = cnt_ff + sts_pkg::QCNT_ONE;
      else if (pop && !push_valid)
         cnt_in = cnt_ff - sts_pkg::QCNT_ONE;
   end

   always_ff @(posedge clock) begin
      if (push_valid)
         q_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== rtl/sts_back.sv =====
module sts_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  sts_pkg::bundle_type head_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sts_pkg::result_type rsp_data,
   output logic                rsp_run_last
);

   logic [1:0]          idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sts_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                load, bundle_done;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_run_last = rsp_last_ff;

   always_comb begin
      load         = head_valid && (!rsp_valid_ff || !rsp_stall);
      bundle_done  = (idx_ff == (head_data.count - 2'd1));
      pop          = load && bundle_done;
      rsp_data_in  = head_data.slot[idx_ff];
      rsp_last_in  = bundle_done;
      rsp_valid_in = rsp_valid_ff;
      if (load)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      idx_in = idx_ff;
      if (load)
         idx_in = bundle_done ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// A byte's result words pass through the queue and then the result register before they reach rsp.
// Throughput: one byte per cycle while the queue is not full; a byte's results (up to three)
// leave one by one, and a four-entry queue between scanner and result register absorbs this.
// Reset (synchronous, active high) returns the scanner to line 1, column 0, no open
// token, and empties the queue and the result register.
module source_text_tokenizer #(
   parameter int POS_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_kind,
   output logic [15:0] rsp_line_no,
   output logic [15:0] rsp_end_col,
   output logic [15:0] rsp_token_len,
   output logic [7:0]  rsp_bad_char,
   output logic        rsp_run_last
);

   // The front end scans one byte per cycle while the queue is not full and works out, in that same cycle,
   // every result word the byte causes: the close of a token that was open,
   // a one-byte operator or error, and on the final byte the flush of any open
   // token followed by the end word. These are packed into one bundle.
   sts_pkg::bundle_type push_data;
   logic                push_valid;
   logic                q_full;

   // The queue holds bundles, so the front end only stalls when it is full.
   sts_pkg::bundle_type head_data;
   logic                head_valid;
   logic                pop;

   // The back end unpacks the head bundle one word per cycle, while rsp_stall does not hold it, into the output
   // register and marks the final word of each bundle with run_last.
   sts_pkg::result_type rsp_data;

   sts_front #(
      .POS_WIDTH (POS_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ch        (req_ch),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .req_stall     (req_stall),
      .push_valid    (push_valid),
      .push_data     (push_data)
   );

   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .q_full     (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   sts_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .rsp_run_last (rsp_run_last)
   );

   // The result word is spread over the field ports.
   assign rsp_kind      = rsp_data.kind;
   assign rsp_line_no   = rsp_data.line_no;
   assign rsp_end_col   = rsp_data.end_col;
   assign rsp_token_len = rsp_data.token_len;
   assign rsp_bad_char  = rsp_data.bad_char;

endmodule

// ===== rtl/sts_checker.sv =====
`include "source_text_tokenizer_defines.svh"

module sts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_kind,
   input logic [15:0] rsp_line_no,
   input logic [15:0] rsp_end_col,
   input logic [15:0] rsp_token_len,
   input logic [7:0]  rsp_bad_char,
   input logic        rsp_run_last
);

   // A stalled result word stays put.
   `STS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_line_no) && $stable(rsp_end_col) && $stable(rsp_token_len) && $stable(rsp_bad_char) && $stable(rsp_run_last))

   // The end word is always the last word caused by its byte.
   `STS_ASSERT_IMPLY(a_end_last, rsp_valid && (rsp_kind == sts_pkg::KIND_END), rsp_run_last)

   // End and error words carry no length.
   `STS_ASSERT_IMPLY(a_len_zero, rsp_valid && ((rsp_kind == sts_pkg::KIND_END) || (rsp_kind == sts_pkg::KIND_ERR)), rsp_token_len == 16'd0)

   // Only error words name an offending byte.
   `STS_ASSERT_IMPLY(a_bad_char, rsp_valid && (rsp_kind != sts_pkg::KIND_ERR), rsp_bad_char == 8'h00)

   // Lines are counted from one.
   `STS_ASSERT_IMPLY(a_line_pos, rsp_valid, rsp_line_no != 16'd0)

endmodule

bind source_text_tokenizer sts_checker u_sts_checker (.*);
